@@ sv/hamming_encode_correct_defines.svh @@
// ----------------------------------------------------------------------------
// Hamming encoder / corrector assertion macros
// Shared concurrent assertion forms for the Hamming block.
// ----------------------------------------------------------------------------
`ifndef HAMMING_ENCODE_CORRECT_DEFINES_SVH
`define HAMMING_ENCODE_CORRECT_DEFINES_SVH

// Same-cycle implication, disabled while reset is held.
`define HEC_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is held.
`define HEC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ sv/hec_pkg.sv @@
// ----------------------------------------------------------------------------
// Hamming encoder / corrector package
// Widths, transaction payload types and the bit-placement functions.
// ----------------------------------------------------------------------------
package hec_pkg;

    localparam int WORD_W        = 63;
    localparam int LEN_W         = 6;
    localparam int KCNT_W        = 3;
    localparam int MAX_CODE_BITS = 63;

    localparam logic [WORD_W-1:0] ALL_ONES = {WORD_W{1'b1}};

    localparam logic OP_ENCODE = 1'b0;
    localparam logic OP_DECODE = 1'b1;

    typedef struct packed {
        logic              op;
        logic [LEN_W-1:0]  word_length;
        logic [WORD_W-1:0] word_in;
    } t_in_item;

    typedef struct packed {
        logic [WORD_W-1:0] word_out;
        logic [LEN_W-1:0]  out_length;
        logic [LEN_W-1:0]  syndrome;
        logic              corrected;
        logic              bad_position;
        logic              length_error;
    } t_out_item;

    // Smallest k with 2^k >= n + k + 1.
    function automatic logic [KCNT_W-1:0] parity_count(input logic [LEN_W-1:0] n);
        logic [KCNT_W-1:0] k;
        if (n == 6'd0) begin
            k = 3'd0;
        end else if (n == 6'd1) begin
            k = 3'd2;
        end else if (n <= 6'd4) begin
            k = 3'd3;
        end else if (n <= 6'd11) begin
            k = 3'd4;
        end else if (n <= 6'd26) begin
            k = 3'd5;
        end else if (n <= 6'd57) begin
            k = 3'd6;
        end else begin
            k = 3'd7;
        end
        return k;
    endfunction

    // Info bits go to the positions that are not powers of two, lowest first.
    // The mapping is fixed, so this is pure wiring.
    function automatic logic [WORD_W-1:0] scatter_data(input logic [WORD_W-1:0] data);
        logic [WORD_W-1:0] r;
        int d;
        r = '0;
        d = 0;
        for (int p = 1; p <= WORD_W; p++) begin
            if ((p & (p - 1)) != 0) begin
                r[p-1] = data[d];
                d++;
            end
        end
        return r;
    endfunction

    // XOR of the positions of all set bits; one XOR tree per syndrome bit.
    function automatic logic [LEN_W-1:0] position_xor(input logic [WORD_W-1:0] w);
        logic [LEN_W-1:0] s;
        s = '0;
        for (int i = 0; i < WORD_W; i++) begin
            if (w[i]) begin
                s ^= LEN_W'(i + 1);
            end
        end
        return s;
    endfunction

    // Puts syndrome bit j on position 2^j.
    function automatic logic [WORD_W-1:0] place_parity(input logic [LEN_W-1:0] s);
        logic [WORD_W-1:0] r;
        r = '0;
        for (int j = 0; j < LEN_W; j++) begin
            r[(1 << j) - 1] = s[j];
        end
        return r;
    endfunction

endpackage

@@ sv/hec_in_if.sv @@
// ----------------------------------------------------------------------------
// Hamming input channel
// Valid/ready channel carrying one input word per transaction.
// ----------------------------------------------------------------------------
interface hec_in_if;
    logic              valid;
    logic              ready;
    hec_pkg::t_in_item payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

@@ sv/hec_out_if.sv @@
// ----------------------------------------------------------------------------
// Hamming output channel
// Valid/ready channel carrying one result word per transaction.
// ----------------------------------------------------------------------------
interface hec_out_if;
    logic               valid;
    logic               ready;
    hec_pkg::t_out_item payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

@@ sv/hamming_encode_correct.sv @@
// ----------------------------------------------------------------------------
// Hamming encoder / single-error corrector
// Three-stage pipeline: mask and place, syndrome, parity insert or correct.
// ----------------------------------------------------------------------------
// The block accepts one transaction per clock while the output is not stalled
// and returns one result per transaction, in order, once it has passed the
// three register stages: input masking and bit placement, the six syndrome
// XOR trees, then parity insertion or bit correction. A stall at the output
// holds every stage in place. In encode mode an info word of length n becomes
// a codeword of n + k bits with even parity bits at the power-of-two
// positions; lengths that need more than 63 code bits raise length_error with
// a zero word. In decode mode the syndrome names the flipped bit, which is
// corrected unless it lies beyond the word length, in which case bad_position
// is raised and the word is passed through masked.
// ----------------------------------------------------------------------------
module hamming_encode_correct (
    input  logic      i_clk,
    input  logic      i_rst_n,
    hec_in_if.sink    i_in,
    hec_out_if.source o_out
);

    `include "hamming_encode_correct_defines.svh"

    localparam int LW = hec_pkg::LEN_W;
    localparam int WW = hec_pkg::WORD_W;

    logic r_v3;

    // The whole pipeline moves when the output register is free or drained.
    logic w_adv;
    assign w_adv       = !r_v3 || o_out.ready;
    assign i_in.ready  = w_adv;

    // ---------------- stage 1: mask, place, length check ----------------
    logic                        r_v1;
    logic                        r_op1;
    logic [LW-1:0]               r_len1;
    logic                        r_lerr1;
    logic [WW-1:0]               r_word1;

    logic [WW-1:0]               w_masked;
    logic [hec_pkg::KCNT_W-1:0]  w_k;
    logic [LW:0]                 w_m;
    logic                        w_enc_lerr;
    logic                        w_dec_lerr;
    logic                        n_lerr1;
    logic [LW-1:0]               n_len1;
    logic [WW-1:0]               n_word1;

    always_comb begin
        w_masked   = i_in.payload.word_in & ~(hec_pkg::ALL_ONES << i_in.payload.word_length);
        w_k        = hec_pkg::parity_count(i_in.payload.word_length);
        w_m        = {1'b0, i_in.payload.word_length} + (LW+1)'(w_k);
        w_enc_lerr = w_m > (LW+1)'(hec_pkg::MAX_CODE_BITS);
        w_dec_lerr = (LW+1)'(i_in.payload.word_length) > (LW+1)'(hec_pkg::MAX_CODE_BITS);
        if (i_in.payload.op == hec_pkg::OP_ENCODE) begin
            n_lerr1 = w_enc_lerr;
            n_len1  = w_enc_lerr ? '0 : w_m[LW-1:0];
            n_word1 = w_enc_lerr ? '0 : hec_pkg::scatter_data(w_masked);
        end else begin
            n_lerr1 = w_dec_lerr;
            n_len1  = w_dec_lerr ? '0 : i_in.payload.word_length;
            n_word1 = w_dec_lerr ? '0 : w_masked;
        end
    end

    // ---------------- stage 2: syndrome ----------------
    logic          r_v2;
    logic          r_op2;
    logic [LW-1:0] r_len2;
    logic          r_lerr2;
    logic [WW-1:0] r_word2;
    logic [LW-1:0] r_syn2;

    // ---------------- stage 3: parity insert or correction ----------------
    hec_pkg::t_out_item r_out;
    hec_pkg::t_out_item n_out;
    logic               w_bad;
    logic               w_flip;

    always_comb begin
        w_bad  = r_syn2 > r_len2;
        w_flip = (r_syn2 != '0) && !w_bad;
        n_out.out_length   = r_len2;
        n_out.length_error = r_lerr2;
        if (r_op2 == hec_pkg::OP_ENCODE) begin
            n_out.word_out     = r_word2 | hec_pkg::place_parity(r_syn2);
            n_out.syndrome     = '0;
            n_out.corrected    = 1'b0;
            n_out.bad_position = 1'b0;
        end else begin
            n_out.word_out     = w_flip ? (r_word2 ^ (WW'(1) << (r_syn2 - LW'(1)))) : r_word2;
            n_out.syndrome     = r_syn2;
            n_out.corrected    = w_flip;
            n_out.bad_position = w_bad;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else if (w_adv) begin
            r_v1 <= i_in.valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_op1   <= i_in.payload.op;
            r_len1  <= n_len1;
            r_lerr1 <= n_lerr1;
            r_word1 <= n_word1;

            r_op2   <= r_op1;
            r_len2  <= r_len1;
            r_lerr2 <= r_lerr1;
            r_word2 <= r_word1;
            r_syn2  <= hec_pkg::position_xor(r_word1);

            r_out   <= n_out;
        end
    end

    assign o_out.valid   = r_v3;
    assign o_out.payload = r_out;

    // ---------------- assertions ----------------
    `HEC_ASSERT_NEXT(a_accept_enters, i_clk, i_rst_n, i_in.valid && i_in.ready, r_v1,
        "accepted transaction did not enter stage 1")
    `HEC_ASSERT_NEXT(a_stage2_moves, i_clk, i_rst_n, r_v2 && w_adv, r_v3,
        "stage 2 item lost on its way to the output register")
    `HEC_ASSERT_NOW(a_lerr_zero, i_clk, i_rst_n, r_v3 && r_out.length_error,
        r_out.word_out == '0 && r_out.out_length == '0 && r_out.syndrome == '0,
        "length error result carries a nonzero word or length")
    `HEC_ASSERT_NOW(a_corr_range, i_clk, i_rst_n, r_v3 && r_out.corrected,
        r_out.syndrome != '0 && r_out.syndrome <= r_out.out_length && !r_out.bad_position,
        "correction reported with a syndrome outside the word")

endmodule

@@ test/hec_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Hamming encoder / corrector checker
// Watches both channels, predicts each result from the accepted input word
// and compares every field of the results in order of arrival.
// ----------------------------------------------------------------------------
module hec_checker (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  logic               i_in_ready,
    input  hec_pkg::t_in_item  i_in_item,
    input  logic               i_out_valid,
    input  logic               i_out_ready,
    input  hec_pkg::t_out_item i_out_item,
    output int                 o_fail_count,
    output int                 o_pending,
    output int                 o_checked
);
    localparam int WORD_W = hec_pkg::WORD_W;
    localparam int LEN_W  = hec_pkg::LEN_W;

    hec_pkg::t_out_item pending_results[$];
    int                 fail_count = 0;
    int                 checked    = 0;

    // XOR of the positions of the set bits among the lowest len positions.
    function automatic logic [LEN_W-1:0] set_position_xor(input logic [WORD_W-1:0] w,
                                                          input int len);
        logic [LEN_W-1:0] s;
        s = '0;
        for (int p = 1; p <= len; p++) begin
            if (w[p-1]) begin
                s ^= LEN_W'(p);
            end
        end
        return s;
    endfunction

    function automatic hec_pkg::t_out_item hamming_result(input hec_pkg::t_in_item it);
        hec_pkg::t_out_item r;
        int                 n;
        int                 k;
        int                 m;
        int                 d;
        logic [WORD_W-1:0]  w;
        logic [LEN_W-1:0]   s;
        r = '0;
        n = it.word_length;
        if (it.op == hec_pkg::OP_ENCODE) begin
            k = 0;
            while ((1 << k) < n + k + 1) begin
                k++;
            end
            m = n + k;
            if (m > hec_pkg::MAX_CODE_BITS) begin
                r.length_error = 1'b1;
            end else begin
                w = '0;
                d = 0;
                for (int p = 1; p <= m; p++) begin
                    if ((p & (p - 1)) != 0) begin
                        w[p-1] = it.word_in[d];
                        d++;
                    end
                end
                // Each parity bit cancels its share of the position XOR.
                s = set_position_xor(w, m);
                for (int j = 0; j < k; j++) begin
                    if (s[j]) begin
                        w[(1 << j) - 1] = 1'b1;
                    end
                end
                r.word_out   = w;
                r.out_length = LEN_W'(m);
            end
        end else begin
            // A six-bit length never exceeds the 63-bit code limit.
            w = (n == 0) ? '0 : it.word_in & (hec_pkg::ALL_ONES >> (WORD_W - n));
            s = set_position_xor(w, n);
            r.word_out   = w;
            r.out_length = LEN_W'(n);
            r.syndrome   = s;
            if (s > n) begin
                r.bad_position = 1'b1;
            end else if (s != 0) begin
                r.word_out[s-1] = ~w[s-1];
                r.corrected     = 1'b1;
            end
        end
        return r;
    endfunction

    task automatic check_field(input string name, input logic [WORD_W-1:0] want,
                               input logic [WORD_W-1:0] got);
        if (want !== got) begin
            $display("%0t: %s differs, expected 0x%0h, actual 0x%0h", $time, name, want, got);
            fail_count++;
        end
    endtask

    always @(posedge i_clk) begin
        hec_pkg::t_out_item want;
        if (i_rst_n) begin
            if (i_out_valid && i_out_ready) begin
                if (pending_results.size() == 0) begin
                    $display("%0t: result transaction, expected none, actual 0x%0h",
                             $time, i_out_item);
                    fail_count++;
                end else begin
                    want = pending_results.pop_front();
                    check_field("word_out", want.word_out, i_out_item.word_out);
                    check_field("out_length", WORD_W'(want.out_length),
                                WORD_W'(i_out_item.out_length));
                    check_field("syndrome", WORD_W'(want.syndrome),
                                WORD_W'(i_out_item.syndrome));
                    check_field("corrected", WORD_W'(want.corrected),
                                WORD_W'(i_out_item.corrected));
                    check_field("bad_position", WORD_W'(want.bad_position),
                                WORD_W'(i_out_item.bad_position));
                    check_field("length_error", WORD_W'(want.length_error),
                                WORD_W'(i_out_item.length_error));
                    checked++;
                end
            end
            if (i_in_valid && i_in_ready) begin
                pending_results.push_back(hamming_result(i_in_item));
            end
        end
        o_fail_count <= fail_count;
        o_pending    <= pending_results.size();
        o_checked    <= checked;
    end

endmodule

@@ test/tb_hamming_encode_correct.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Hamming encoder / corrector testbench
// Drives directed and random encode and decode words with random idle and
// stall bursts, and reports the verdict from the checker's failure count.
// ----------------------------------------------------------------------------
module tb_hamming_encode_correct;

    localparam int WORD_W = hec_pkg::WORD_W;
    localparam int LEN_W  = hec_pkg::LEN_W;
    localparam logic [WORD_W-1:0] ALL_ONES = hec_pkg::ALL_ONES;

    localparam int RANDOM_WORDS = 400;
    localparam int CALM_WORDS   = 80;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int DRAIN_CYCLES = 8;

    logic clk;
    logic rst_n;
    logic calm;
    int   stall_left  = 0;
    int   cycle_count = 0;
    int   encode_sent = 0;
    int   decode_sent = 0;
    int   errors_injected = 0;
    int   fail_count;
    int   pending_count;
    int   checked_count;

    hec_in_if  in_ch ();
    hec_out_if out_ch ();

    hamming_encode_correct DUT (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    hec_checker u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_ch.valid),
        .i_in_ready   (in_ch.ready),
        .i_in_item    (in_ch.payload),
        .i_out_valid  (out_ch.valid),
        .i_out_ready  (out_ch.ready),
        .i_out_item   (out_ch.payload),
        .o_fail_count (fail_count),
        .o_pending    (pending_count),
        .o_checked    (checked_count)
    );

    initial begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // Result side: ready drops for bursts of random length until the calm tail.
    always @(posedge clk) begin
        if (!rst_n) begin
            stall_left   <= 0;
            out_ch.ready <= 1'b1;
        end else if (stall_left > 1) begin
            stall_left <= stall_left - 1;
        end else if (stall_left == 1) begin
            stall_left   <= 0;
            out_ch.ready <= 1'b1;
        end else if (!calm && $urandom_range(0, 4) == 0) begin
            stall_left   <= $urandom_range(1, 13);
            out_ch.ready <= 1'b0;
        end
    end

    function automatic logic [WORD_W-1:0] random_word();
        logic [63:0] r;
        r = {$urandom(), $urandom()};
        return r[WORD_W-1:0];
    endfunction

    function automatic logic [LEN_W-1:0] position_parity(input logic [WORD_W-1:0] w,
                                                         input int len);
        logic [LEN_W-1:0] s;
        s = '0;
        for (int p = 1; p <= len; p++) begin
            if (w[p-1]) begin
                s ^= LEN_W'(p);
            end
        end
        return s;
    endfunction

    // Random bits of the given length, turned into a clean codeword by one flip
    // where the syndrome allows it, then with a bit error at err_pos (0 for none).
    // With dirty set, garbage is placed above the length.
    function automatic logic [WORD_W-1:0] make_codeword(input int len, input int err_pos,
                                                        input logic dirty);
        logic [WORD_W-1:0] w;
        logic [LEN_W-1:0]  s;
        w = random_word();
        if (len < WORD_W) begin
            w &= ~(ALL_ONES << len);
        end
        s = position_parity(w, len);
        if (s != 0 && s <= len) begin
            w[s-1] = ~w[s-1];
        end
        if (err_pos != 0) begin
            w[err_pos-1] = ~w[err_pos-1];
        end
        if (dirty && len < WORD_W) begin
            w |= random_word() & (ALL_ONES << len);
        end
        return w;
    endfunction

    task automatic send_word(input logic op, input int len, input logic [WORD_W-1:0] w);
        if (!calm && $urandom_range(0, 3) == 0) begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge clk);
        end
        in_ch.valid   <= 1'b1;
        in_ch.payload <= hec_pkg::t_in_item'{op, LEN_W'(len), w};
        if (op == hec_pkg::OP_ENCODE) begin
            encode_sent++;
        end else begin
            decode_sent++;
        end
        do begin
            @(posedge clk);
        end while (!in_ch.ready);
    endtask

    initial begin
        int n;
        int err_pos;
        rst_n         <= 1'b0;
        calm          <= 1'b0;
        in_ch.valid   <= 1'b0;
        in_ch.payload <= '0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Encode: empty word, each parity-count boundary, the longest legal
        // length, too-long lengths and ignored bits above the length.
        send_word(hec_pkg::OP_ENCODE, 0, ALL_ONES);
        send_word(hec_pkg::OP_ENCODE, 1, WORD_W'(1));
        send_word(hec_pkg::OP_ENCODE, 4, WORD_W'(15));
        send_word(hec_pkg::OP_ENCODE, 11, WORD_W'(12'h5A5));
        send_word(hec_pkg::OP_ENCODE, 26, ALL_ONES);
        send_word(hec_pkg::OP_ENCODE, 57, ALL_ONES);
        send_word(hec_pkg::OP_ENCODE, 57, {32'h5555_5555, 31'h2AAA_AAAA});
        send_word(hec_pkg::OP_ENCODE, 58, ALL_ONES);
        send_word(hec_pkg::OP_ENCODE, 63, ALL_ONES);
        send_word(hec_pkg::OP_ENCODE, 5, ALL_ONES);

        // Decode: empty word, clean words, single errors at the ends, a
        // syndrome beyond the length and masked bits above the length.
        send_word(hec_pkg::OP_DECODE, 0, ALL_ONES);
        send_word(hec_pkg::OP_DECODE, 7, '0);
        send_word(hec_pkg::OP_DECODE, 7, WORD_W'(1) << 4);
        send_word(hec_pkg::OP_DECODE, 4, WORD_W'(4'b1011));
        send_word(hec_pkg::OP_DECODE, 63, '0);
        send_word(hec_pkg::OP_DECODE, 63, ALL_ONES);
        send_word(hec_pkg::OP_DECODE, 63, ALL_ONES >> 1);
        send_word(hec_pkg::OP_DECODE, 63, WORD_W'(1) << 62);
        send_word(hec_pkg::OP_DECODE, 3, ALL_ONES);
        send_word(hec_pkg::OP_DECODE, 1, WORD_W'(1));
        send_word(hec_pkg::OP_DECODE, 10,
                  (WORD_W'(1) << 2) | (WORD_W'(1) << 7) | (WORD_W'(1) << 11));
        send_word(hec_pkg::OP_DECODE, 63, make_codeword(63, 32, 1'b0));
        send_word(hec_pkg::OP_DECODE, 40, make_codeword(40, 0, 1'b1));

        for (int i = 0; i < RANDOM_WORDS; i++) begin
            if (i == RANDOM_WORDS - CALM_WORDS) begin
                calm <= 1'b1;
            end
            n = $urandom_range(0, 63);
            if ($urandom_range(0, 9) < 4) begin
                send_word(hec_pkg::OP_ENCODE, n, random_word());
            end else if ($urandom_range(0, 9) < 8) begin
                err_pos = (n > 0 && $urandom_range(0, 9) < 7) ? $urandom_range(1, n) : 0;
                if (err_pos != 0) begin
                    errors_injected++;
                end
                send_word(hec_pkg::OP_DECODE, n,
                          make_codeword(n, err_pos, $urandom_range(0, 2) == 0));
            end else begin
                send_word(hec_pkg::OP_DECODE, n, random_word());
            end
        end
        in_ch.valid <= 1'b0;

        @(posedge clk);
        while (pending_count != 0) begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Sent %0d encode and %0d decode transactions, %0d with one injected bit error.",
                 encode_sent, decode_sent, errors_injected);
        $display("Compared %0d results field by field under random idle and stall bursts.",
                 checked_count);
        if (fail_count == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
